// ===== rtl/sorted_task_min_max_queue_defines.svh =====
// Assertion macros shared by the sorted task queue RTL.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef SORTED_TASK_MIN_MAX_QUEUE_DEFINES_SVH
`define SORTED_TASK_MIN_MAX_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define STQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted task queue: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted task queue: next-cycle check failed");
`else
`define STQ_ASSERT_SAME(label, ante, cons)
`define STQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/stq_pkg.sv =====
// Shared types and constants for the sorted task queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package stq_pkg;

  // Default number of stored tasks.
  localparam int DEF_CAPACITY = 16;

  // Field widths.
  localparam int DUR_W  = 16;
  localparam int HND_W  = 8;
  localparam int FILL_W = 5;

  // Entries per group in the registered tail select.
  localparam int TAIL_GRP = 16;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_SUBMIT    = 2'd0,
    REQ_FETCH_MIN = 2'd1,
    REQ_FETCH_MAX = 2'd2
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

// ===== rtl/stq_ctrl.sv =====
// Controller of the sorted task queue: sequences accept and execute.
// Depends on stq_pkg.
module stq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output stq_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // Load the request on accept; execute it in the following cycle.
  assign cmd.load = start && !busy;
  assign cmd.exec = (state == S_EXEC);

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/stq_datapath.sv =====
// Datapath of the sorted task queue: sorted shift array of cells, valid
// thermometer, task count, registered tail select and result registers.
// Depends on stq_pkg.
module stq_datapath #(
  parameter int CAPACITY = stq_pkg::DEF_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst,
  input  stq_pkg::cmd_t              cmd,
  input  logic [1:0]                 req_type,
  input  logic [stq_pkg::DUR_W-1:0]  task_dur,
  input  logic [stq_pkg::HND_W-1:0]  task_handle,
  output stq_pkg::dp_stat_t          stat,
  output logic [1:0]                 status,
  output logic                       got_task,
  output logic [stq_pkg::HND_W-1:0]  out_handle,
  output logic [stq_pkg::DUR_W-1:0]  out_duration,
  output logic [stq_pkg::FILL_W-1:0] fill_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int GRP   = stq_pkg::TAIL_GRP;
  localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;
  localparam int PAD   = NGRP * GRP;
  localparam int DW    = stq_pkg::DUR_W;
  localparam int HW    = stq_pkg::HND_W;

  // Captured request.
  stq_pkg::req_t  req;
  logic [DW-1:0]  req_dur;
  logic [HW-1:0]  req_hnd;

  // Cell array, kept sorted by ascending duration.
  logic [DW-1:0]       dur [CAPACITY];
  logic [HW-1:0]       hnd [CAPACITY];
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]    count;

  logic [DW-1:0]       dur_next [CAPACITY];
  logic [HW-1:0]       hnd_next [CAPACITY];
  logic [CAPACITY-1:0] valid_next;
  logic [CNT_W-1:0]    count_next;

  // Neighbor views of the array.
  logic [DW-1:0]       up_dur   [CAPACITY];
  logic [HW-1:0]       up_hnd   [CAPACITY];
  logic [DW-1:0]       down_dur [CAPACITY];
  logic [HW-1:0]       down_hnd [CAPACITY];
  logic [CAPACITY-1:0] le;
  logic [CAPACITY-1:0] le_prev;
  logic [CAPACITY-1:0] last;

  // Tail select.
  logic [PAD-1:0]  last_pad;
  logic [DW-1:0]   dur_pad  [PAD];
  logic [HW-1:0]   hnd_pad  [PAD];
  logic [DW-1:0]   grp_dur_next [NGRP];
  logic [HW-1:0]   grp_hnd_next [NGRP];
  logic [DW-1:0]   grp_dur [NGRP];
  logic [HW-1:0]   grp_hnd [NGRP];
  logic [DW-1:0]   tail_dur;
  logic [HW-1:0]   tail_hnd;

  // Result of the current request.
  stq_pkg::status_t res_status;
  logic             res_got;
  logic [DW-1:0]    res_dur;
  logic [HW-1:0]    res_hnd;
  stq_pkg::status_t status_reg;

  assign stat.empty = !valid[0];
  assign stat.full  = valid[CAPACITY-1];

  // Capture the request on accept.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req     <= stq_pkg::req_t'(req_type);
      req_dur <= task_dur;
      req_hnd <= task_handle;
    end
  end

  // Per-cell compare, last-entry flags and shifted neighbor values.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = valid[i] && (dur[i] <= req_dur);
    end
    le_prev = {le[CAPACITY-2:0], 1'b1};
    last    = valid & ~{1'b0, valid[CAPACITY-1:1]};
    up_dur[0] = req_dur;
    up_hnd[0] = req_hnd;
    for (int i = 1; i < CAPACITY; i++) begin
      up_dur[i] = dur[i-1];
      up_hnd[i] = hnd[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      down_dur[i] = dur[i+1];
      down_hnd[i] = hnd[i+1];
    end
    down_dur[CAPACITY-1] = dur[CAPACITY-1];
    down_hnd[CAPACITY-1] = hnd[CAPACITY-1];
  end

  // First level of the tail select: one-hot pick inside each group.
  always_comb begin
    last_pad = PAD'(last);
    for (int i = 0; i < CAPACITY; i++) begin
      dur_pad[i] = dur[i];
      hnd_pad[i] = hnd[i];
    end
    for (int i = CAPACITY; i < PAD; i++) begin
      dur_pad[i] = '0;
      hnd_pad[i] = '0;
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_dur_next[g] = '0;
      grp_hnd_next[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        grp_dur_next[g] = grp_dur_next[g] | (last_pad[g*GRP+j] ? dur_pad[g*GRP+j] : '0);
        grp_hnd_next[g] = grp_hnd_next[g] | (last_pad[g*GRP+j] ? hnd_pad[g*GRP+j] : '0);
      end
    end
  end

  // Group results follow the array; they settle in the accept cycle.
  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_dur[g] <= grp_dur_next[g];
      grp_hnd[g] <= grp_hnd_next[g];
    end
  end

  // Second level: at most one group holds the last entry.
  always_comb begin
    tail_dur = '0;
    tail_hnd = '0;
    for (int g = 0; g < NGRP; g++) begin
      tail_dur = tail_dur | grp_dur[g];
      tail_hnd = tail_hnd | grp_hnd[g];
    end
  end

  // Next array contents and the result for the request.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      dur_next[i] = dur[i];
      hnd_next[i] = hnd[i];
    end
    valid_next = valid;
    count_next = count;
    res_status = stq_pkg::ST_DONE;
    res_got    = 1'b0;
    res_dur    = '0;
    res_hnd    = '0;
    case (req)
      stq_pkg::REQ_SUBMIT: begin
        if (stat.full) begin
          res_status = stq_pkg::ST_FULL;
        end else begin
          // Cells past the insert point move up by one.
          for (int i = 0; i < CAPACITY; i++) begin
            if (!le[i]) begin
              if (le_prev[i]) begin
                dur_next[i] = req_dur;
                hnd_next[i] = req_hnd;
              end else begin
                dur_next[i] = up_dur[i];
                hnd_next[i] = up_hnd[i];
              end
            end
          end
          valid_next = {valid[CAPACITY-2:0], 1'b1};
          count_next = count + CNT_W'(1);
        end
      end
      stq_pkg::REQ_FETCH_MIN: begin
        if (stat.empty) begin
          res_status = stq_pkg::ST_EMPTY;
        end else begin
          res_got = 1'b1;
          res_dur = dur[0];
          res_hnd = hnd[0];
          for (int i = 0; i < CAPACITY; i++) begin
            dur_next[i] = down_dur[i];
            hnd_next[i] = down_hnd[i];
          end
          valid_next = {1'b0, valid[CAPACITY-1:1]};
          count_next = count - CNT_W'(1);
        end
      end
      stq_pkg::REQ_FETCH_MAX: begin
        if (stat.empty) begin
          res_status = stq_pkg::ST_EMPTY;
        end else begin
          res_got    = 1'b1;
          res_dur    = tail_dur;
          res_hnd    = tail_hnd;
          valid_next = valid & ~last;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        res_status = stq_pkg::ST_DONE;
      end
    endcase
  end

  // Control state of the array.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      valid <= valid_next;
      count <= count_next;
    end
  end

  // Cell payload and result registers.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        dur[i] <= dur_next[i];
        hnd[i] <= hnd_next[i];
      end
      status_reg   <= res_status;
      got_task     <= res_got;
      out_duration <= res_dur;
      out_handle   <= res_hnd;
      fill_count   <= stq_pkg::FILL_W'(count_next);
    end
  end

  assign status = status_reg;

endmodule

// ===== rtl/sorted_task_min_max_queue.sv =====
// Top level of the sorted task queue: controller plus datapath.
// Depends on stq_pkg, stq_ctrl, stq_datapath and the assertion macro header.

// Sorted task queue with removal of the shortest or the longest task. A request
// is taken at the clock edge where start is high and busy is low; busy then
// stays high for one execute cycle, and the result appears on the result ports
// in the next cycle with done high for exactly that one cycle. The receiver
// cannot stall, so results must be captured when done is high. A new request
// may be started in the same cycle that done is high, but not before the last item
// has executed. That step is set by the execute cycle: the longest
// task is read through a registered two-level select over the cell array, whose
// first level settles in the accept cycle. Equal durations leave in arrival
// order from the short end and in reverse from the long end. No clearing pass
// runs after reset.
`include "sorted_task_min_max_queue_defines.svh"

module sorted_task_min_max_queue #(
  parameter int CAPACITY = stq_pkg::DEF_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type,
  input  logic [stq_pkg::DUR_W-1:0]  task_dur,
  input  logic [stq_pkg::HND_W-1:0]  task_handle,
  output logic                       done,
  output logic [1:0]                 status,
  output logic                       got_task,
  output logic [stq_pkg::HND_W-1:0]  out_handle,
  output logic [stq_pkg::DUR_W-1:0]  out_duration,
  output logic [stq_pkg::FILL_W-1:0] fill_count
);

  stq_pkg::cmd_t     cmd;
  stq_pkg::dp_stat_t stat;

  // Request sequencing.
  stq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Cell array and result registers.
  stq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (req_type),
    .task_dur     (task_dur),
    .task_handle  (task_handle),
    .stat         (stat),
    .status       (status),
    .got_task     (got_task),
    .out_handle   (out_handle),
    .out_duration (out_duration),
    .fill_count   (fill_count)
  );

  // An accepted item goes to the execute cycle, and its result follows it.
  `STQ_ASSERT_NEXT(a_accept_exec, start && !busy, busy && cmd.exec)
  `STQ_ASSERT_NEXT(a_exec_done, cmd.exec, done && !busy)
  // A returned task always comes with a plain done status.
  `STQ_ASSERT_SAME(a_got_status, done && got_task, status == stq_pkg::ST_DONE)
  // A full queue is never empty.
  `STQ_ASSERT_SAME(a_full_not_empty, stat.full, !stat.empty)

endmodule

// ===== sim/stq_checker.sv =====
// Checker for the sorted task queue: watches the request and result channels.
// Keeps its own copy of the sorted task list and compares every result.
// Depends on stq_pkg for field widths, request codes and status codes.
module stq_checker
  import stq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        req_type,
  input  logic [DUR_W-1:0]  task_dur,
  input  logic [HND_W-1:0]  task_handle,
  input  logic              done,
  input  logic [1:0]        status,
  input  logic              got_task,
  input  logic [HND_W-1:0]  out_handle,
  input  logic [DUR_W-1:0]  out_duration,
  input  logic [FILL_W-1:0] fill_count,
  output int                mismatches,
  output int                outstanding
);

  typedef struct {
    logic [1:0]        st;
    logic              got;
    logic [HND_W-1:0]  hnd;
    logic [DUR_W-1:0]  dur;
    logic [FILL_W-1:0] fill;
  } task_result_t;

  // Predicted queue contents, sorted by ascending duration.
  logic [DUR_W-1:0] sorted_dur [CAPACITY];
  logic [HND_W-1:0] sorted_hnd [CAPACITY];
  int               task_count;

  task_result_t expected_results[$];
  task_result_t oldest_expected;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    task_count  = 0;
  end

  // Applies one request to the predicted queue and returns the result it yields.
  function automatic task_result_t serve_request(logic [1:0] req, logic [DUR_W-1:0] dur,
                                                 logic [HND_W-1:0] hnd);
    task_result_t r;
    int pos;
    int i;
    r.st  = ST_DONE;
    r.got = 1'b0;
    r.hnd = '0;
    r.dur = '0;
    case (req)
      REQ_SUBMIT: begin
        if (task_count >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          // Equal durations go behind the ones already stored.
          pos = 0;
          while (pos < task_count && sorted_dur[pos] <= dur) pos++;
          for (i = task_count; i > pos; i--) begin
            sorted_dur[i] = sorted_dur[i-1];
            sorted_hnd[i] = sorted_hnd[i-1];
          end
          sorted_dur[pos] = dur;
          sorted_hnd[pos] = hnd;
          task_count++;
        end
      end
      REQ_FETCH_MIN, REQ_FETCH_MAX: begin
        if (task_count == 0) begin
          r.st = ST_EMPTY;
        end else if (req == REQ_FETCH_MIN) begin
          r.got = 1'b1;
          r.dur = sorted_dur[0];
          r.hnd = sorted_hnd[0];
          for (i = 1; i < task_count; i++) begin
            sorted_dur[i-1] = sorted_dur[i];
            sorted_hnd[i-1] = sorted_hnd[i];
          end
          task_count--;
        end else begin
          r.got = 1'b1;
          r.dur = sorted_dur[task_count-1];
          r.hnd = sorted_hnd[task_count-1];
          task_count--;
        end
      end
      default: begin
        // The unused request code leaves the queue alone.
      end
    endcase
    r.fill = FILL_W'(task_count);
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, actual %0d", name, want, seen);
      mismatches++;
    end
  endtask

  // A result on the strobe belongs to an earlier item, so it is checked before
  // an item accepted at the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      task_count = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result strobe with no item outstanding");
          mismatches++;
        end else begin
          oldest_expected = expected_results.pop_front();
          compare_field("status", oldest_expected.st, status);
          compare_field("got_task", oldest_expected.got, got_task);
          compare_field("out_handle", oldest_expected.hnd, out_handle);
          compare_field("out_duration", oldest_expected.dur, out_duration);
          compare_field("fill_count", oldest_expected.fill, fill_count);
        end
      end
      if (start && !busy) begin
        expected_results.push_back(serve_request(req_type, task_dur, task_handle));
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== sim/tb_sorted_task_min_max_queue.sv =====
// Testbench top for the sorted task queue: clock, reset, request stimulus, verdict.
// Depends on stq_pkg, the sorted_task_min_max_queue RTL and stq_checker.
module tb_sorted_task_min_max_queue;
  import stq_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 650;
  localparam int IDLE_PCT = 22;
  localparam int CYCLE_LIMIT = 200000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        req_type;
  logic [DUR_W-1:0]  task_dur;
  logic [HND_W-1:0]  task_handle;
  logic              done;
  logic [1:0]        status;
  logic              got_task;
  logic [HND_W-1:0]  out_handle;
  logic [DUR_W-1:0]  out_duration;
  logic [FILL_W-1:0] fill_count;
  int                mismatches;
  int                outstanding;
  int                cycle_count;

  sorted_task_min_max_queue #(.CAPACITY(CAPACITY)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .task_dur(task_dur), .task_handle(task_handle),
    .done(done), .status(status), .got_task(got_task), .out_handle(out_handle),
    .out_duration(out_duration), .fill_count(fill_count)
  );

  stq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .task_dur(task_dur), .task_handle(task_handle),
    .done(done), .status(status), .got_task(got_task), .out_handle(out_handle),
    .out_duration(out_duration), .fill_count(fill_count),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Presents one item, possibly after a random gap, and holds it until accepted.
  task automatic issue_request(logic [1:0] req, logic [DUR_W-1:0] dur,
                               logic [HND_W-1:0] hnd, int idle_pct);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start       <= 1'b1;
    req_type    <= req;
    task_dur    <= dur;
    task_handle <= hnd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stops sending until every outstanding result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Durations are drawn mostly from a narrow range so that ties are common.
  function automatic logic [DUR_W-1:0] pick_duration();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return DUR_W'($urandom_range(0, 15));
    if (roll < 58) return '0;
    if (roll < 66) return '1;
    return DUR_W'($urandom);
  endfunction

  function automatic logic [1:0] pick_request(int submit_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return REQ_UNUSED;
    if (roll < submit_pct) return REQ_SUBMIT;
    return ($urandom_range(1) == 0) ? REQ_FETCH_MIN : REQ_FETCH_MAX;
  endfunction

  initial begin
    int n;
    int submit_pct;
    int idle_pct;
    rst         = 1'b1;
    start       = 1'b0;
    req_type    = REQ_SUBMIT;
    task_dur    = '0;
    task_handle = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty fetches and the unused code on an empty queue.
    issue_request(REQ_FETCH_MIN, 16'h1234, 8'hAA, IDLE_PCT);
    issue_request(REQ_FETCH_MAX, 16'hFFFF, 8'hFF, IDLE_PCT);
    issue_request(REQ_UNUSED, 16'h00FF, 8'h55, IDLE_PCT);

    // Fill to capacity with extreme and repeated durations and handles.
    for (n = 0; n < CAPACITY; n++) begin
      case (n % 4)
        0: issue_request(REQ_SUBMIT, '1, HND_W'(n * 17), IDLE_PCT);
        1: issue_request(REQ_SUBMIT, '0, HND_W'(n * 17), IDLE_PCT);
        default: issue_request(REQ_SUBMIT, DUR_W'(100 + n % 3), HND_W'(n * 17), IDLE_PCT);
      endcase
    end

    // Full queue rejects, then both ends and the unused code on a full queue.
    issue_request(REQ_SUBMIT, 16'h0001, 8'h01, IDLE_PCT);
    issue_request(REQ_UNUSED, 16'hFFFF, 8'hFF, IDLE_PCT);
    issue_request(REQ_FETCH_MAX, 16'h0000, 8'h00, IDLE_PCT);
    issue_request(REQ_FETCH_MIN, 16'h0000, 8'h00, IDLE_PCT);
    issue_request(REQ_FETCH_MIN, 16'hFFFF, 8'hFF, IDLE_PCT);

    // Random part: phases that lean toward filling, draining or neither.
    submit_pct = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(2))
          0: submit_pct = 78;
          1: submit_pct = 28;
          default: submit_pct = 52;
        endcase
      end
      if (n == 200 || n == 500) wait_for_results();
      idle_pct = (n >= 300 && n < 420) ? 0 : IDLE_PCT;
      issue_request(pick_request(submit_pct), pick_duration(), HND_W'($urandom),
                    idle_pct);
    end

    // Drain and let the last result settle.
    wait_for_results();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
